// ----- rtl/buddy_block_allocator_core_defines.svh -----
// ----------------------------------------------------------------------------
// Buddy block allocator assertion macros
// Shared concurrent assertion forms, clocked on i_clk, held off in reset.
// ----------------------------------------------------------------------------
`ifndef BUDDY_BLOCK_ALLOCATOR_CORE_DEFINES_SVH
`define BUDDY_BLOCK_ALLOCATOR_CORE_DEFINES_SVH

// same-cycle implication
`define BBA_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define BBA_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/bba_pkg.sv -----
// ----------------------------------------------------------------------------
// Buddy block allocator package
// Field widths, operation and status codes, controller states, and the
// command and status words between controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package bba_pkg;

    localparam int OP_W     = 2;
    localparam int SIZE_W   = 27;
    localparam int HANDLE_W = 15;
    localparam int ORD_W    = 4;
    localparam int CNT_W    = 16;
    localparam int BYTES_W  = 22;
    localparam int TAKEN_W  = 5;

    typedef enum logic [OP_W-1:0] {
        OP_ALLOC  = 2'd0,
        OP_FREE   = 2'd1,
        OP_RESIZE = 2'd2
    } t_op;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_BAD_SIZE = 2'd1,
        ST_NO_SPACE = 2'd2,
        ST_IGNORED  = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        CNT_NONE,
        CNT_SPLIT,
        CNT_MERGE,
        CNT_TAKE,
        CNT_RELEASE
    } t_cnt_op;

    typedef enum logic [4:0] {
        S_CLEAR,
        S_IDLE,
        S_LOOK,
        S_DECIDE,
        S_SCAN,
        S_SCAN_W,
        S_SPL_A,
        S_SPL_B,
        S_SPL_C,
        S_FR_INIT,
        S_FR_RD,
        S_FR_CHK,
        S_FR_M1,
        S_FR_M2,
        S_FR_M3,
        S_GR_RD,
        S_GR_CHK,
        S_GR_INIT,
        S_GR_W,
        S_GR_END,
        S_RESP
    } t_state;

    typedef struct packed {
        logic             fm_we;
        logic             fm_wdata;
        logic             tk_we;
        t_cnt_op          cnt_op;
        logic [ORD_W-1:0] cnt_ord;
    } t_dp_ctrl;

    typedef struct packed {
        logic               fm_rdata;
        logic [TAKEN_W-1:0] tk_rdata;
        logic [CNT_W-1:0]   free_blocks;
        logic [BYTES_W-1:0] free_bytes;
        logic [CNT_W-1:0]   used_blocks;
        logic [BYTES_W-1:0] used_bytes;
    } t_dp_stat;

endpackage

`default_nettype wire

// ----- rtl/bba_if.sv -----
// ----------------------------------------------------------------------------
// Buddy block allocator channels
// Request and response valid/ready channels with source and sink modports.
// ----------------------------------------------------------------------------
`default_nettype none

interface bba_req_if import bba_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [OP_W-1:0]     op;
    logic [SIZE_W-1:0]   request_size;
    logic [HANDLE_W-1:0] block_handle;

    modport source (output valid, op, request_size, block_handle, input ready);
    modport sink   (input valid, op, request_size, block_handle, output ready);
endinterface

interface bba_rsp_if import bba_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [1:0]          status;
    logic [HANDLE_W-1:0] block_start;
    logic [ORD_W-1:0]    block_order;
    logic [CNT_W-1:0]    free_blocks;
    logic [BYTES_W-1:0]  free_bytes;
    logic [CNT_W-1:0]    used_blocks;
    logic [BYTES_W-1:0]  used_bytes;

    modport source (output valid, status, block_start, block_order, free_blocks,
                    free_bytes, used_blocks, used_bytes, input ready);
    modport sink   (input valid, status, block_start, block_order, free_blocks,
                    free_bytes, used_blocks, used_bytes, output ready);
endinterface

`default_nettype wire

// ----- rtl/bba_dpath.sv -----
// ----------------------------------------------------------------------------
// Buddy block allocator datapath
// Free node map, taken order map and the block and byte counters.
// ----------------------------------------------------------------------------
`default_nettype none

module bba_dpath import bba_pkg::*; #(
    parameter int MAX_ORDER_LEVEL = 10,
    parameter int TOP_BLOCKS      = 32,
    parameter int MIN_BLOCK_BYTES = 128,
    parameter int HEADER_BYTES    = 40,
    parameter int FMW             = 16,
    parameter int UBW             = 15
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire t_dp_ctrl           i_ctrl,
    input  wire logic [FMW-1:0]     i_fm_addr,
    input  wire logic [UBW-1:0]     i_tk_addr,
    input  wire logic [TAKEN_W-1:0] i_tk_wdata,
    output t_dp_stat                o_stat
);

    localparam int FM_DEPTH = TOP_BLOCKS << (MAX_ORDER_LEVEL + 1);
    localparam int UNITS    = TOP_BLOCKS << MAX_ORDER_LEVEL;
    localparam logic [BYTES_W-1:0] TOP_PAYLOAD =
        BYTES_W'((MIN_BLOCK_BYTES << MAX_ORDER_LEVEL) - HEADER_BYTES);
    localparam logic [BYTES_W-1:0] RST_BYTES = BYTES_W'(TOP_BLOCKS * TOP_PAYLOAD);
    localparam logic [BYTES_W-1:0] HDR = BYTES_W'(HEADER_BYTES);

    logic               r_fm_mem [FM_DEPTH];
    logic [TAKEN_W-1:0] r_tk_mem [UNITS];
    logic               r_fm_q;
    logic [TAKEN_W-1:0] r_tk_q;
    logic [CNT_W-1:0]   r_free_blocks, n_free_blocks;
    logic [BYTES_W-1:0] r_free_bytes, n_free_bytes;
    logic [CNT_W-1:0]   r_used_blocks, n_used_blocks;
    logic [BYTES_W-1:0] r_used_bytes, n_used_bytes;
    logic [BYTES_W-1:0] w_payload;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.fm_we) begin
            r_fm_mem[i_fm_addr] <= i_ctrl.fm_wdata;
        end
        r_fm_q <= r_fm_mem[i_fm_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.tk_we) begin
            r_tk_mem[i_tk_addr] <= i_tk_wdata;
        end
        r_tk_q <= r_tk_mem[i_tk_addr];
    end

    assign w_payload = BYTES_W'((32'(MIN_BLOCK_BYTES) << i_ctrl.cnt_ord)
                                - 32'(HEADER_BYTES));

    always_comb begin
        n_free_blocks = r_free_blocks;
        n_free_bytes  = r_free_bytes;
        n_used_blocks = r_used_blocks;
        n_used_bytes  = r_used_bytes;
        case (i_ctrl.cnt_op)
            CNT_SPLIT: begin
                n_used_blocks = r_used_blocks + 1'b1;
                n_used_bytes  = r_used_bytes - HDR;
                n_free_blocks = r_free_blocks + 1'b1;
                n_free_bytes  = r_free_bytes - HDR;
            end
            CNT_MERGE: begin
                n_used_blocks = r_used_blocks - 1'b1;
                n_used_bytes  = r_used_bytes + HDR;
                n_free_blocks = r_free_blocks - 1'b1;
                n_free_bytes  = r_free_bytes + HDR;
            end
            CNT_TAKE: begin
                n_free_blocks = r_free_blocks - 1'b1;
                n_free_bytes  = r_free_bytes - w_payload;
            end
            CNT_RELEASE: begin
                n_free_blocks = r_free_blocks + 1'b1;
                n_free_bytes  = r_free_bytes + w_payload;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_free_blocks <= CNT_W'(TOP_BLOCKS);
            r_used_blocks <= CNT_W'(TOP_BLOCKS);
            r_free_bytes  <= RST_BYTES;
            r_used_bytes  <= RST_BYTES;
        end else begin
            r_free_blocks <= n_free_blocks;
            r_used_blocks <= n_used_blocks;
            r_free_bytes  <= n_free_bytes;
            r_used_bytes  <= n_used_bytes;
        end
    end

    assign o_stat.fm_rdata    = r_fm_q;
    assign o_stat.tk_rdata    = r_tk_q;
    assign o_stat.free_blocks = r_free_blocks;
    assign o_stat.free_bytes  = r_free_bytes;
    assign o_stat.used_blocks = r_used_blocks;
    assign o_stat.used_bytes  = r_used_bytes;

endmodule

`default_nettype wire

// ----- rtl/bba_ctrl.sv -----
// ----------------------------------------------------------------------------
// Buddy block allocator controller
// Sequences lookup, search, split, coalesce and in-place growth over the
// datapath maps, and holds the response word.
// ----------------------------------------------------------------------------
`default_nettype none

`include "buddy_block_allocator_core_defines.svh"

module bba_ctrl import bba_pkg::*; #(
    parameter int MAX_ORDER_LEVEL = 10,
    parameter int TOP_BLOCKS      = 32,
    parameter int MIN_BLOCK_BYTES = 128,
    parameter int HEADER_BYTES    = 40,
    parameter int MAX_REQUEST     = 100000000,
    parameter int FMW             = 16,
    parameter int UBW             = 15
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    bba_req_if.sink                  i_req,
    bba_rsp_if.source                o_rsp,
    input  wire t_dp_stat            i_stat,
    output t_dp_ctrl                 o_ctrl,
    output logic [FMW-1:0]           o_fm_addr,
    output logic [UBW-1:0]           o_tk_addr,
    output logic [TAKEN_W-1:0]       o_tk_wdata
);

    localparam int FM_DEPTH = TOP_BLOCKS << (MAX_ORDER_LEVEL + 1);
    localparam int UNITS    = TOP_BLOCKS << MAX_ORDER_LEVEL;
    localparam int UW1      = UBW + 1;
    localparam int HW       = MAX_ORDER_LEVEL + 1;

    t_state              r_state, n_state;
    logic [OP_W-1:0]     r_op, n_op;
    logic [SIZE_W-1:0]   r_size, n_size;
    logic [HANDLE_W-1:0] r_h, n_h;
    logic [UW1-1:0]      r_u, n_u;
    logic [4:0]          r_o, n_o;
    logic [ORD_W-1:0]    r_cur, n_cur;
    t_status             r_status, n_status;
    logic [HANDLE_W-1:0] r_start, n_start;
    logic [ORD_W-1:0]    r_ord, n_ord;
    logic [FMW-1:0]      r_clr, n_clr;
    logic                r_ov, n_ov;
    t_status             r_o_status, n_o_status;
    logic [HANDLE_W-1:0] r_o_start, n_o_start;
    logic [ORD_W-1:0]    r_o_ord, n_o_ord;
    logic [CNT_W-1:0]    r_o_fblk, n_o_fblk;
    logic [BYTES_W-1:0]  r_o_fbyte, n_o_fbyte;
    logic [CNT_W-1:0]    r_o_ublk, n_o_ublk;
    logic [BYTES_W-1:0]  r_o_ubyte, n_o_ubyte;

    logic [ORD_W-1:0]    w_mo;
    logic                w_fit;
    logic                w_bad;
    logic [UBW-1:0]      w_hu;
    logic                w_taken;

    function automatic logic [FMW-1:0] node(input logic [UBW-1:0] u, input logic [3:0] o);
        logic [MAX_ORDER_LEVEL-1:0] off;
        logic [HW-1:0]              heap;
        off  = u[MAX_ORDER_LEVEL-1:0];
        heap = (HW'(1) << (MAX_ORDER_LEVEL - int'(o))) | HW'(off >> o);
        return {u[UBW-1:MAX_ORDER_LEVEL], heap};
    endfunction

    function automatic logic [UW1-1:0] bitm(input logic [4:0] o);
        return UW1'(1) << o;
    endfunction

    always_comb begin
        logic [32:0] need;
        w_mo  = '0;
        w_fit = 1'b0;
        need  = 33'(r_size) + 33'(HEADER_BYTES);
        for (int o = MAX_ORDER_LEVEL; o >= 0; o--) begin
            if ((33'(MIN_BLOCK_BYTES) << o) >= need) begin
                w_mo  = ORD_W'(o);
                w_fit = 1'b1;
            end
        end
    end

    assign w_bad   = (r_size == '0) || (32'(r_size) > 32'(MAX_REQUEST)) || !w_fit;
    assign w_hu    = UBW'(r_h);
    assign w_taken = (32'(r_h) < 32'(UNITS)) && (i_stat.tk_rdata != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            r_ov    <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op       <= n_op;
        r_size     <= n_size;
        r_h        <= n_h;
        r_u        <= n_u;
        r_o        <= n_o;
        r_cur      <= n_cur;
        r_status   <= n_status;
        r_start    <= n_start;
        r_ord      <= n_ord;
        r_o_status <= n_o_status;
        r_o_start  <= n_o_start;
        r_o_ord    <= n_o_ord;
        r_o_fblk   <= n_o_fblk;
        r_o_fbyte  <= n_o_fbyte;
        r_o_ublk   <= n_o_ublk;
        r_o_ubyte  <= n_o_ubyte;
    end

    always_comb begin
        logic [UW1-1:0] nu;
        logic [4:0]     no;
        n_state    = r_state;
        n_op       = r_op;
        n_size     = r_size;
        n_h        = r_h;
        n_u        = r_u;
        n_o        = r_o;
        n_cur      = r_cur;
        n_status   = r_status;
        n_start    = r_start;
        n_ord      = r_ord;
        n_clr      = r_clr;
        n_ov       = r_ov;
        n_o_status = r_o_status;
        n_o_start  = r_o_start;
        n_o_ord    = r_o_ord;
        n_o_fblk   = r_o_fblk;
        n_o_fbyte  = r_o_fbyte;
        n_o_ublk   = r_o_ublk;
        n_o_ubyte  = r_o_ubyte;
        nu         = r_u;
        no         = r_o;
        o_ctrl     = '{fm_we: 1'b0, fm_wdata: 1'b0, tk_we: 1'b0,
                       cnt_op: CNT_NONE, cnt_ord: '0};
        o_fm_addr  = node(r_u[UBW-1:0], r_o[3:0]);
        o_tk_addr  = r_u[UBW-1:0];
        o_tk_wdata = '0;
        i_req.ready = 1'b0;

        if (r_ov && o_rsp.ready) begin
            n_ov = 1'b0;
        end

        unique case (r_state)
            S_CLEAR: begin
                o_ctrl.fm_we    = 1'b1;
                o_ctrl.fm_wdata = (r_clr[HW-1:0] == HW'(1));
                o_fm_addr       = r_clr;
                o_ctrl.tk_we    = (32'(r_clr) < 32'(UNITS));
                o_tk_addr       = UBW'(r_clr);
                n_clr           = r_clr + 1'b1;
                if (r_clr == FMW'(FM_DEPTH - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                i_req.ready = 1'b1;
                if (i_req.valid) begin
                    n_op     = i_req.op;
                    n_size   = i_req.request_size;
                    n_h      = i_req.block_handle;
                    n_status = ST_OK;
                    n_start  = '0;
                    n_ord    = '0;
                    n_state  = S_LOOK;
                end
            end
            S_LOOK: begin
                o_tk_addr = w_hu;
                n_state   = S_DECIDE;
            end
            S_DECIDE: begin
                n_cur = ORD_W'(i_stat.tk_rdata - 1'b1);
                case (r_op)
                    OP_ALLOC: begin
                        if (w_bad) begin
                            n_status = ST_BAD_SIZE;
                            n_state  = S_RESP;
                        end else begin
                            n_u     = '0;
                            n_o     = 5'(w_mo);
                            n_state = S_SCAN;
                        end
                    end
                    OP_FREE: begin
                        if (!w_taken) begin
                            n_status = ST_IGNORED;
                            n_state  = S_RESP;
                        end else begin
                            n_u     = UW1'(w_hu);
                            n_o     = 5'(n_cur);
                            n_state = S_FR_INIT;
                        end
                    end
                    OP_RESIZE: begin
                        if (w_bad) begin
                            n_status = ST_BAD_SIZE;
                            n_state  = S_RESP;
                        end else if (!w_taken) begin
                            n_status = ST_IGNORED;
                            n_state  = S_RESP;
                        end else if (((32'(MIN_BLOCK_BYTES) << n_cur) - 32'(HEADER_BYTES))
                                     >= 32'(r_size)) begin
                            n_start = r_h;
                            n_ord   = n_cur;
                            n_state = S_RESP;
                        end else begin
                            n_u     = UW1'(w_hu);
                            n_o     = 5'(n_cur);
                            n_state = S_GR_RD;
                        end
                    end
                    default: begin
                        n_status = ST_IGNORED;
                        n_state  = S_RESP;
                    end
                endcase
            end
            S_SCAN: begin
                n_state = S_SCAN_W;
            end
            S_SCAN_W: begin
                if (i_stat.fm_rdata) begin
                    n_state = S_SPL_A;
                end else begin
                    nu = r_u + bitm(r_o);
                    if (nu >= UW1'(UNITS)) begin
                        if (32'(r_o) >= 32'(MAX_ORDER_LEVEL)) begin
                            n_status = ST_NO_SPACE;
                            n_state  = S_RESP;
                        end else begin
                            n_o     = r_o + 1'b1;
                            n_u     = '0;
                            n_state = S_SCAN;
                        end
                    end else begin
                        n_u     = nu;
                        n_state = S_SCAN;
                    end
                end
            end
            S_SPL_A: begin
                o_ctrl.fm_we = 1'b1;
                if (r_o > 5'(w_mo)) begin
                    n_state = S_SPL_B;
                end else begin
                    o_ctrl.tk_we   = 1'b1;
                    o_tk_wdata     = TAKEN_W'(w_mo) + 1'b1;
                    o_ctrl.cnt_op  = CNT_TAKE;
                    o_ctrl.cnt_ord = w_mo;
                    n_start        = HANDLE_W'(r_u);
                    n_ord          = w_mo;
                    if (r_op == OP_RESIZE) begin
                        n_u     = UW1'(w_hu);
                        n_o     = 5'(r_cur);
                        n_state = S_FR_INIT;
                    end else begin
                        n_state = S_RESP;
                    end
                end
            end
            S_SPL_B: begin
                no              = r_o - 1'b1;
                o_ctrl.fm_we    = 1'b1;
                o_ctrl.fm_wdata = 1'b1;
                o_fm_addr       = node(r_u[UBW-1:0], no[3:0]);
                n_state         = S_SPL_C;
            end
            S_SPL_C: begin
                no              = r_o - 1'b1;
                nu              = r_u + bitm(no);
                o_ctrl.fm_we    = 1'b1;
                o_ctrl.fm_wdata = 1'b1;
                o_fm_addr       = node(nu[UBW-1:0], no[3:0]);
                o_ctrl.cnt_op   = CNT_SPLIT;
                n_o             = no;
                n_state         = S_SPL_A;
            end
            S_FR_INIT: begin
                o_ctrl.tk_we    = 1'b1;
                o_ctrl.fm_we    = 1'b1;
                o_ctrl.fm_wdata = 1'b1;
                o_ctrl.cnt_op   = CNT_RELEASE;
                o_ctrl.cnt_ord  = r_o[3:0];
                n_state         = S_FR_RD;
            end
            S_FR_RD: begin
                nu        = r_u ^ bitm(r_o);
                o_fm_addr = node(nu[UBW-1:0], r_o[3:0]);
                if (32'(r_o) >= 32'(MAX_ORDER_LEVEL)) begin
                    n_state = S_RESP;
                end else begin
                    n_state = S_FR_CHK;
                end
            end
            S_FR_CHK: begin
                n_state = i_stat.fm_rdata ? S_FR_M1 : S_RESP;
            end
            S_FR_M1: begin
                o_ctrl.fm_we = 1'b1;
                n_state      = S_FR_M2;
            end
            S_FR_M2: begin
                nu           = r_u ^ bitm(r_o);
                o_ctrl.fm_we = 1'b1;
                o_fm_addr    = node(nu[UBW-1:0], r_o[3:0]);
                n_state      = S_FR_M3;
            end
            S_FR_M3: begin
                nu              = r_u & ~bitm(r_o);
                no              = r_o + 1'b1;
                o_ctrl.fm_we    = 1'b1;
                o_ctrl.fm_wdata = 1'b1;
                o_fm_addr       = node(nu[UBW-1:0], no[3:0]);
                o_ctrl.cnt_op   = CNT_MERGE;
                n_u             = nu;
                n_o             = no;
                n_state         = S_FR_RD;
            end
            S_GR_RD: begin
                nu        = r_u ^ bitm(r_o);
                o_fm_addr = node(nu[UBW-1:0], r_o[3:0]);
                n_state   = S_GR_CHK;
            end
            S_GR_CHK: begin
                if (!i_stat.fm_rdata) begin
                    n_u     = '0;
                    n_o     = 5'(w_mo);
                    n_state = S_SCAN;
                end else begin
                    nu = r_u & ~bitm(r_o);
                    no = r_o + 1'b1;
                    if (no == 5'(w_mo)) begin
                        n_u     = UW1'(w_hu);
                        n_o     = 5'(r_cur);
                        n_state = S_GR_INIT;
                    end else begin
                        n_u     = nu;
                        n_o     = no;
                        n_state = S_GR_RD;
                    end
                end
            end
            S_GR_INIT: begin
                o_ctrl.tk_we   = 1'b1;
                o_ctrl.cnt_op  = CNT_RELEASE;
                o_ctrl.cnt_ord = r_cur;
                n_state        = S_GR_W;
            end
            S_GR_W: begin
                nu            = r_u ^ bitm(r_o);
                no            = r_o + 1'b1;
                o_ctrl.fm_we  = 1'b1;
                o_fm_addr     = node(nu[UBW-1:0], r_o[3:0]);
                o_ctrl.cnt_op = CNT_MERGE;
                n_u           = r_u & ~bitm(r_o);
                n_o           = no;
                n_state       = (no == 5'(w_mo)) ? S_GR_END : S_GR_W;
            end
            S_GR_END: begin
                o_ctrl.tk_we   = 1'b1;
                o_tk_wdata     = TAKEN_W'(w_mo) + 1'b1;
                o_ctrl.cnt_op  = CNT_TAKE;
                o_ctrl.cnt_ord = w_mo;
                n_start        = HANDLE_W'(r_u);
                n_ord          = w_mo;
                n_state        = S_RESP;
            end
            S_RESP: begin
                if (!r_ov || o_rsp.ready) begin
                    n_ov       = 1'b1;
                    n_o_status = r_status;
                    n_o_start  = (r_status == ST_OK) ? r_start : '0;
                    n_o_ord    = (r_status == ST_OK) ? r_ord : '0;
                    n_o_fblk   = i_stat.free_blocks;
                    n_o_fbyte  = i_stat.free_bytes;
                    n_o_ublk   = i_stat.used_blocks;
                    n_o_ubyte  = i_stat.used_bytes;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_rsp.valid       = r_ov;
    assign o_rsp.status      = r_o_status;
    assign o_rsp.block_start = r_o_start;
    assign o_rsp.block_order = r_o_ord;
    assign o_rsp.free_blocks = r_o_fblk;
    assign o_rsp.free_bytes  = r_o_fbyte;
    assign o_rsp.used_blocks = r_o_ublk;
    assign o_rsp.used_bytes  = r_o_ubyte;

    `BBA_ASSERT_NXT(a_rsp_hold, r_state == S_RESP && r_ov && !o_rsp.ready,
                    r_state == S_RESP, "response word overwritten before taken")
    `BBA_ASSERT_IMP(a_split_floor, r_state == S_SPL_A, r_o >= 5'(w_mo),
                    "split went below target order")
    `BBA_ASSERT_IMP(a_idle_quiet, r_state == S_IDLE, !o_ctrl.fm_we && !o_ctrl.tk_we,
                    "map written while idle")
    `BBA_ASSERT_IMP(a_merge_top, r_state == S_FR_CHK, 32'(r_o) < 32'(MAX_ORDER_LEVEL),
                    "coalesce past top order")

endmodule

`default_nettype wire

// ----- rtl/buddy_block_allocator_core.sv -----
// ----------------------------------------------------------------------------
// Buddy block allocator core
// Binary buddy allocator over a pool of top blocks: allocate, free, resize.
//
//   channel   dir   word
//   i_req     in    op, request_size, block_handle
//   o_rsp     out   status, block_start, block_order, counters
//
// After reset a clearing pass over the node map runs with i_req held off.
// One request at a time: the order search probes node by node, splits, coalesces and
// in-place growth go level by level, and buddies are checked one at a time, all
// paced by the single-port node map.
// A response waits in its register while o_rsp stalls; i_req reopens once it is loaded.
// ----------------------------------------------------------------------------
`default_nettype none

module buddy_block_allocator_core import bba_pkg::*; #(
    parameter int MAX_ORDER_LEVEL = 10,
    parameter int TOP_BLOCKS      = 32,
    parameter int MIN_BLOCK_BYTES = 128,
    parameter int HEADER_BYTES    = 40,
    parameter int MAX_REQUEST     = 100000000
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    bba_req_if.sink   i_req,
    bba_rsp_if.source o_rsp
);

    localparam int TOPW = (TOP_BLOCKS > 1) ? $clog2(TOP_BLOCKS) : 1;
    localparam int FMW  = TOPW + MAX_ORDER_LEVEL + 1;
    localparam int UBW  = TOPW + MAX_ORDER_LEVEL;

    t_dp_ctrl           w_ctrl;
    t_dp_stat           w_stat;
    logic [FMW-1:0]     w_fm_addr;
    logic [UBW-1:0]     w_tk_addr;
    logic [TAKEN_W-1:0] w_tk_wdata;

    bba_ctrl #(
        .MAX_ORDER_LEVEL (MAX_ORDER_LEVEL),
        .TOP_BLOCKS      (TOP_BLOCKS),
        .MIN_BLOCK_BYTES (MIN_BLOCK_BYTES),
        .HEADER_BYTES    (HEADER_BYTES),
        .MAX_REQUEST     (MAX_REQUEST),
        .FMW             (FMW),
        .UBW             (UBW)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (i_req),
        .o_rsp      (o_rsp),
        .i_stat     (w_stat),
        .o_ctrl     (w_ctrl),
        .o_fm_addr  (w_fm_addr),
        .o_tk_addr  (w_tk_addr),
        .o_tk_wdata (w_tk_wdata)
    );

    bba_dpath #(
        .MAX_ORDER_LEVEL (MAX_ORDER_LEVEL),
        .TOP_BLOCKS      (TOP_BLOCKS),
        .MIN_BLOCK_BYTES (MIN_BLOCK_BYTES),
        .HEADER_BYTES    (HEADER_BYTES),
        .FMW             (FMW),
        .UBW             (UBW)
    ) u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctrl     (w_ctrl),
        .i_fm_addr  (w_fm_addr),
        .i_tk_addr  (w_tk_addr),
        .i_tk_wdata (w_tk_wdata),
        .o_stat     (w_stat)
    );

endmodule

`default_nettype wire

// ----- sim/buddy_block_allocator_core_test.sv -----
// ----------------------------------------------------------------------------
// Buddy block allocator core testbench
// Drives allocate, free, resize and unused op words into the core, predicts every
// response with a local buddy tree model and checks each response field by
// field, under random idling on both channels and long response stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module buddy_block_allocator_core_test;
    import bba_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_ORD   = 10;
    localparam int TOPS      = 32;
    localparam int MIN_BYTES = 128;
    localparam int HDR       = 40;
    localparam int MAX_REQ   = 100000000;
    localparam int TREE      = (2 << MAX_ORD) - 1;
    localparam int UNITS     = TOPS << MAX_ORD;
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    typedef struct packed {
        t_status             status;
        logic [HANDLE_W-1:0] start;
        logic [ORD_W-1:0]    order;
        logic [CNT_W-1:0]    free_blocks;
        logic [BYTES_W-1:0]  free_bytes;
        logic [CNT_W-1:0]    used_blocks;
        logic [BYTES_W-1:0]  used_bytes;
    } t_reply;

    logic i_clk;
    logic i_rst_n;

    bba_req_if req_ch ();
    bba_rsp_if rsp_ch ();

    buddy_block_allocator_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    bit          node_free [TOPS*TREE];
    logic [4:0]  taken_ord [UNITS];
    int unsigned n_free_blk, n_free_byte, n_blk, n_byte;

    t_reply      pending_replies[$];
    int          live_handles[$];
    int          errors;
    int          tx_idle_pct;
    int          rx_idle_pct;
    int          stall_request;
    int          stall_left;

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    function automatic int node_index(int u, int o);
        return (u >> MAX_ORD) * TREE + (1 << (MAX_ORD - o))
               + ((u & ((1 << MAX_ORD) - 1)) >> o) - 1;
    endfunction

    function automatic int unsigned payload_bytes(int o);
        return (MIN_BYTES << o) - HDR;
    endfunction

    function automatic int fit_order(longint size);
        for (int o = 0; o <= MAX_ORD; o++) begin
            if ((longint'(MIN_BYTES) << o) >= size + HDR) return o;
        end
        return -1;
    endfunction

    function automatic void merge_counts();
        n_blk--;
        n_byte += HDR;
        n_free_blk--;
        n_free_byte += HDR;
    endfunction

    function automatic int carve_block(int mo);
        int  o;
        int  u;
        bit  found;
        found = 0;
        u = 0;
        for (o = mo; o <= MAX_ORD; o++) begin
            for (u = 0; u < UNITS; u += (1 << o)) begin
                if (node_free[node_index(u, o)]) begin
                    found = 1;
                    break;
                end
            end
            if (found) break;
        end
        if (!found) return -1;
        for (; o > mo; o--) begin
            node_free[node_index(u, o)] = 0;
            node_free[node_index(u, o - 1)] = 1;
            node_free[node_index(u + (1 << (o - 1)), o - 1)] = 1;
            n_blk++;
            n_byte -= HDR;
            n_free_blk++;
            n_free_byte -= HDR;
        end
        node_free[node_index(u, mo)] = 0;
        n_free_blk--;
        n_free_byte -= payload_bytes(mo);
        taken_ord[u] = 5'(mo + 1);
        return u;
    endfunction

    function automatic void release_block(int u, int o);
        int b;
        taken_ord[u] = '0;
        node_free[node_index(u, o)] = 1;
        n_free_blk++;
        n_free_byte += payload_bytes(o);
        while (o < MAX_ORD) begin
            b = u ^ (1 << o);
            if (!node_free[node_index(b, o)]) break;
            node_free[node_index(u, o)] = 0;
            node_free[node_index(b, o)] = 0;
            u &= ~(1 << o);
            o++;
            node_free[node_index(u, o)] = 1;
            merge_counts();
        end
    endfunction

    function automatic t_reply apply_request(logic [OP_W-1:0] op, logic [SIZE_W-1:0] size,
                                             logic [HANDLE_W-1:0] h);
        t_reply r;
        bit     taken;
        bit     bad;
        bit     ok;
        int     cur;
        int     mo;
        int     u;
        int     got;
        r = '0;
        r.status = ST_OK;
        taken = (taken_ord[h] != 0);
        cur = taken ? int'(taken_ord[h]) - 1 : 0;
        mo = fit_order(longint'(size));
        bad = (size == 0) || (size > MAX_REQ) || (mo < 0);
        case (op)
            OP_ALLOC: begin
                if (bad) begin
                    r.status = ST_BAD_SIZE;
                end else begin
                    got = carve_block(mo);
                    if (got < 0) r.status = ST_NO_SPACE;
                    else begin
                        r.start = HANDLE_W'(got);
                        r.order = ORD_W'(mo);
                    end
                end
            end
            OP_FREE: begin
                if (!taken) r.status = ST_IGNORED;
                else release_block(int'(h), cur);
            end
            OP_RESIZE: begin
                if (bad) begin
                    r.status = ST_BAD_SIZE;
                end else if (!taken) begin
                    r.status = ST_IGNORED;
                end else if (payload_bytes(cur) >= size) begin
                    r.start = h;
                    r.order = ORD_W'(cur);
                end else begin
                    ok = 1;
                    u = int'(h);
                    for (int o = cur; o < mo; o++) begin
                        if (!node_free[node_index(u ^ (1 << o), o)]) begin
                            ok = 0;
                            break;
                        end
                        u &= ~(1 << o);
                    end
                    if (ok) begin
                        u = int'(h);
                        taken_ord[h] = '0;
                        n_free_blk++;
                        n_free_byte += payload_bytes(cur);
                        for (int o = cur; o < mo; o++) begin
                            node_free[node_index(u ^ (1 << o), o)] = 0;
                            u &= ~(1 << o);
                            merge_counts();
                        end
                        n_free_blk--;
                        n_free_byte -= payload_bytes(mo);
                        taken_ord[u] = 5'(mo + 1);
                        r.start = HANDLE_W'(u);
                        r.order = ORD_W'(mo);
                    end else begin
                        got = carve_block(mo);
                        if (got < 0) r.status = ST_NO_SPACE;
                        else begin
                            r.start = HANDLE_W'(got);
                            r.order = ORD_W'(mo);
                            release_block(int'(h), cur);
                        end
                    end
                end
            end
            default: r.status = ST_IGNORED;
        endcase
        r.free_blocks = n_free_blk[CNT_W-1:0];
        r.free_bytes  = n_free_byte[BYTES_W-1:0];
        r.used_blocks = n_blk[CNT_W-1:0];
        r.used_bytes  = n_byte[BYTES_W-1:0];
        return r;
    endfunction

    function automatic void track_handles(logic [OP_W-1:0] op, int h, t_reply r);
        int idx[$];
        if (r.status != ST_OK) return;
        if (op == OP_FREE || op == OP_RESIZE) begin
            idx = live_handles.find_first_index(x) with (x == h);
            if (idx.size() > 0) live_handles.delete(idx[0]);
        end
        if (op == OP_ALLOC || op == OP_RESIZE) live_handles.push_back(int'(r.start));
    endfunction

    task automatic report_mismatch(string field, longint got, longint want);
        $display("mismatch %s: got %0d, expected %0d at %0t", field, got, want, $realtime);
        errors++;
    endtask

    // hold the word until accepted, then predict
    task automatic send_word(logic [OP_W-1:0] op, longint size, int h);
        t_reply r;
        if ($urandom_range(99) < tx_idle_pct) begin
            req_ch.valid = 1'b0;
            repeat ($urandom_range(4, 1)) @(negedge i_clk);
        end
        req_ch.valid = 1'b1;
        req_ch.op = op;
        req_ch.request_size = SIZE_W'(size);
        req_ch.block_handle = HANDLE_W'(h);
        forever begin
            @(posedge i_clk);
            if (req_ch.ready) break;
            @(negedge i_clk);
        end
        r = apply_request(op, req_ch.request_size, req_ch.block_handle);
        pending_replies.push_back(r);
        track_handles(op, int'(req_ch.block_handle), r);
        @(negedge i_clk);
        req_ch.valid = 1'b0;
    endtask

    function automatic longint pick_size();
        int o;
        o = ($urandom_range(99) < 85) ? $urandom_range(MAX_ORD, 4) : $urandom_range(3, 0);
        if (o == 0) return longint'($urandom_range(payload_bytes(0), 1));
        return longint'($urandom_range(payload_bytes(o), (MIN_BYTES << (o - 1)) - HDR + 1));
    endfunction

    task automatic wait_drained();
        while (pending_replies.size() > 0) @(negedge i_clk);
    endtask

    task automatic random_item();
        int r;
        int h;
        r = $urandom_range(99);
        if (live_handles.size() > 60 && r < 40) r = 50;
        if (live_handles.size() == 0 && r >= 40 && r < 88) r = 0;
        h = (live_handles.size() > 0) ?
            live_handles[$urandom_range(live_handles.size() - 1)] : 0;
        if (r < 40) send_word(OP_ALLOC, pick_size(), $urandom);
        else if (r < 70) send_word(OP_FREE, $urandom, h);
        else if (r < 88) send_word(OP_RESIZE, pick_size(), h);
        else send_word(OP_W'($urandom_range(3)), $urandom, $urandom);
    endtask

    always @(posedge i_clk) begin
        t_reply want;
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            if (pending_replies.size() == 0) begin
                report_mismatch("unexpected word", 1, 0);
            end else begin
                want = pending_replies.pop_front();
                if (rsp_ch.status != want.status)
                    report_mismatch("status", rsp_ch.status, want.status);
                if (rsp_ch.block_start != want.start)
                    report_mismatch("block_start", rsp_ch.block_start, want.start);
                if (rsp_ch.block_order != want.order)
                    report_mismatch("block_order", rsp_ch.block_order, want.order);
                if (rsp_ch.free_blocks != want.free_blocks)
                    report_mismatch("free_blocks", rsp_ch.free_blocks, want.free_blocks);
                if (rsp_ch.free_bytes != want.free_bytes)
                    report_mismatch("free_bytes", rsp_ch.free_bytes, want.free_bytes);
                if (rsp_ch.used_blocks != want.used_blocks)
                    report_mismatch("used_blocks", rsp_ch.used_blocks, want.used_blocks);
                if (rsp_ch.used_bytes != want.used_bytes)
                    report_mismatch("used_bytes", rsp_ch.used_bytes, want.used_bytes);
            end
        end
    end

    always @(negedge i_clk) begin
        if (stall_request > 0) begin
            stall_left = stall_request;
            stall_request = 0;
        end
        if (stall_left > 0) begin
            rsp_ch.ready = 1'b0;
            stall_left--;
        end else begin
            rsp_ch.ready = ($urandom_range(99) >= rx_idle_pct);
        end
    end

    task automatic test_directed();
        for (int i = 0; i < TOPS; i++) send_word(OP_ALLOC, payload_bytes(MAX_ORD), 0);
        send_word(OP_ALLOC, 1, 0);
        send_word(OP_RESIZE, 1, 0);
        send_word(OP_FREE, 0, 1024);
        send_word(OP_ALLOC, 1, 0);
        send_word(OP_ALLOC, payload_bytes(0), 0);
        send_word(OP_RESIZE, 200, 1024);
        send_word(OP_RESIZE, payload_bytes(MAX_ORD), 1028);
        send_word(OP_FREE, 0, 1025);
        send_word(OP_RESIZE, payload_bytes(MAX_ORD), 1028);
        send_word(OP_FREE, 0, 0);
        send_word(OP_FREE, 0, 0);
        send_word(OP_FREE, 0, 1);
        send_word(OP_FREE, 0, '1);
        send_word(OP_RESIZE, 0, 5);
        send_word(OP_RESIZE, 10, 5);
        send_word(OP_UNUSED, 1, 0);
        send_word(OP_ALLOC, '1, '1);
        send_word(OP_ALLOC, MAX_REQ, 0);
        send_word(OP_ALLOC, payload_bytes(MAX_ORD) + 1, 0);
        send_word(OP_ALLOC, 0, 0);
        send_word(OP_ALLOC, payload_bytes(0) + 1, 0);
        while (live_handles.size() > 0) send_word(OP_FREE, 0, live_handles[0]);
    endtask

    task automatic test_random(int n, int tx_pct, int rx_pct);
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        for (int i = 0; i < n; i++) begin
            random_item();
            if (i == n / 2) wait_drained();
        end
    endtask

    task automatic test_backpressure();
        tx_idle_pct = 0;
        stall_request = 400;
        for (int i = 0; i < 12; i++) random_item();
        wait_drained();
    endtask

    initial begin
        errors = 0;
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        stall_request = 0;
        stall_left = 0;
        i_rst_n = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.op = OP_ALLOC;
        req_ch.request_size = '0;
        req_ch.block_handle = '0;
        rsp_ch.ready = 1'b0;
        for (int i = 0; i < TOPS * TREE; i++) node_free[i] = 0;
        for (int i = 0; i < UNITS; i++) taken_ord[i] = '0;
        for (int t = 0; t < TOPS; t++) node_free[t * TREE] = 1;
        n_free_blk = TOPS;
        n_blk = TOPS;
        n_free_byte = TOPS * payload_bytes(MAX_ORD);
        n_byte = n_free_byte;
        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;
        test_directed();
        test_random(500, 29, 75);
        test_backpressure();
        test_random(500, 75, 29);
        test_random(500, 0, 0);
        wait_drained();
        repeat (50) @(negedge i_clk);
        if (errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    initial begin
        #20s;
        $display("*** FAILED ***");
        $finish;
    end

endmodule

`default_nettype wire
